// ===== hw/rtl/gbs_pkg.sv =====
// Shared constants, payload types and state encoding for the box suppression block.
package gbs_pkg;

    localparam int MAX_KEPT_DEF   = 64;
    localparam int COORD_BITS_DEF = 16;
    localparam int EDGE_W         = 16;
    localparam int INDEX_W        = 16;
    localparam int THRESH_W       = 16;
    localparam int COORD_MAX_W    = 24;
    localparam int FRAC_SHIFT     = 16;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd32768;

    typedef logic [THRESH_W-1:0] thresh_t;

    typedef struct packed {
        logic [INDEX_W-1:0]       box_index;
        logic signed [EDGE_W-1:0] left_edge;
        logic signed [EDGE_W-1:0] top_edge;
        logic signed [EDGE_W-1:0] right_edge;
        logic signed [EDGE_W-1:0] bottom_edge;
        logic                     last_box;
    } box_req_t;

    typedef struct packed {
        logic [INDEX_W-1:0] result_index;
        logic               kept;
        logic               store_overflow;
        logic               set_done;
    } box_res_t;

    typedef struct packed {
        logic busy;
        logic hit;
    } iou_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } gbs_state_t;

endpackage

// ===== hw/rtl/gbs_stream_if.sv =====
// Valid/ready request channel with a typed payload.
interface gbs_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

// ===== hw/rtl/greedy_box_suppression.sv =====
// Greedy box suppression top level: candidate control, kept-box ring and result register.
// Each accepted request passes PREP, a SCAN of the n boxes held for the current set,
// n running from 0 to MAX_KEPT, one stored box per cycle, then DRAIN and FINISH.
// No new request is taken before FINISH is left; the next request is
// taken while a finished result still waits in the output register.
// Reset: the stored-box count clears to zero, the threshold returns to 32768 and
// both channels come up empty; stored box contents are not cleared.
module greedy_box_suppression #(
    parameter int MAX_KEPT   = gbs_pkg::MAX_KEPT_DEF,
    parameter int COORD_BITS = gbs_pkg::COORD_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    gbs_stream_if.sink    box_in,
    gbs_stream_if.source  result_out,
    gbs_stream_if.sink    cfg
);
    localparam int C     = COORD_BITS;
    localparam int D     = C + 1;
    localparam int AW    = 2 * D;
    localparam int CNT_W = $clog2(MAX_KEPT + 1);
    localparam int BOX_W = 4 * C;
    localparam int PADW  = gbs_pkg::COORD_MAX_W - gbs_pkg::EDGE_W;

    // Control state
    gbs_pkg::gbs_state_t state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    step_reg, step_next;
    logic                hit_reg, hit_next;
    gbs_pkg::thresh_t    thr_reg, thr_next;
    logic                out_valid_reg, out_valid_next;
    gbs_pkg::box_res_t   out_data_reg, out_data_next;

    // Candidate held for the whole scan
    logic [gbs_pkg::INDEX_W-1:0] cand_idx_reg;
    logic signed [C-1:0]         cand_x0_reg, cand_y0_reg, cand_x1_reg, cand_y1_reg;
    logic                        cand_last_reg;
    logic signed [AW-1:0]        cand_area_reg;

    logic in_accept, issue, slot_free, finish_fire, store_fire, keep, full;
    gbs_pkg::iou_status_t iou_status;

    // Edges: take the low COORD_BITS of the zero-extended field as two's complement
    logic [gbs_pkg::COORD_MAX_W-1:0] wide_x0, wide_y0, wide_x1, wide_y1;
    logic signed [C-1:0]             in_x0, in_y0, in_x1, in_y1;
    logic signed [D-1:0]             cdx, cdy;

    assign wide_x0 = {{PADW{1'b0}}, box_in.payload.left_edge};
    assign wide_y0 = {{PADW{1'b0}}, box_in.payload.top_edge};
    assign wide_x1 = {{PADW{1'b0}}, box_in.payload.right_edge};
    assign wide_y1 = {{PADW{1'b0}}, box_in.payload.bottom_edge};
    assign in_x0 = $signed(wide_x0[C-1:0]);
    assign in_y0 = $signed(wide_y0[C-1:0]);
    assign in_x1 = $signed(wide_x1[C-1:0]);
    assign in_y1 = $signed(wide_y1[C-1:0]);

    assign cdx = $signed({cand_x1_reg[C-1], cand_x1_reg}) - $signed({cand_x0_reg[C-1], cand_x0_reg});
    assign cdy = $signed({cand_y1_reg[C-1], cand_y1_reg}) - $signed({cand_y0_reg[C-1], cand_y0_reg});

    // Handshakes
    assign in_accept   = box_in.valid && box_in.ready;
    assign slot_free   = !out_valid_reg || result_out.ready;
    assign full        = (count_reg == CNT_W'(MAX_KEPT));
    assign keep        = !hit_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gbs_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = gbs_pkg::ST_PREP;
                end
            end
            gbs_pkg::ST_PREP:
            begin
                state_next = gbs_pkg::ST_SCAN;
            end
            gbs_pkg::ST_SCAN:
            begin
                if (step_reg == count_reg)
                begin
                    state_next = gbs_pkg::ST_DRAIN;
                end
            end
            gbs_pkg::ST_DRAIN:
            begin
                if (!iou_status.busy)
                begin
                    state_next = gbs_pkg::ST_FINISH;
                end
            end
            gbs_pkg::ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = gbs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gbs_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer
    always_comb
    begin
        box_in.ready = 1'b0;
        issue        = 1'b0;
        finish_fire  = 1'b0;
        unique case (state_reg)
            gbs_pkg::ST_IDLE:   box_in.ready = 1'b1;
            gbs_pkg::ST_PREP:   ;
            gbs_pkg::ST_SCAN:   issue = (step_reg != count_reg);
            gbs_pkg::ST_DRAIN:  ;
            gbs_pkg::ST_FINISH: finish_fire = slot_free;
            default:            ;
        endcase
    end

    assign store_fire = finish_fire && keep && !full;

    // Datapath next values
    always_comb
    begin
        step_next      = step_reg;
        hit_next       = hit_reg | iou_status.hit;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        thr_next       = thr_reg;

        if (cfg.valid)
        begin
            thr_next = cfg.payload;
        end

        if (in_accept)
        begin
            // Open a new scan from the head of the ring
            step_next = '0;
            hit_next  = 1'b0;
        end
        else if (issue)
        begin
            step_next = step_reg + CNT_W'(1);
        end

        if (out_valid_reg && result_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (finish_fire)
        begin
            out_valid_next              = 1'b1;
            out_data_next.result_index  = cand_idx_reg;
            out_data_next.kept          = keep;
            out_data_next.store_overflow = keep && full;
            out_data_next.set_done      = cand_last_reg;
            priority if (cand_last_reg)
            begin
                count_next = '0;
            end
            else if (store_fire)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gbs_pkg::ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            hit_reg       <= 1'b0;
            thr_reg       <= gbs_pkg::THRESH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            hit_reg       <= hit_next;
            thr_reg       <= thr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (in_accept)
        begin
            cand_idx_reg  <= box_in.payload.box_index;
            cand_x0_reg   <= in_x0;
            cand_y0_reg   <= in_y0;
            cand_x1_reg   <= in_x1;
            cand_y1_reg   <= in_y1;
            cand_last_reg <= box_in.payload.last_box;
        end
        if (state_reg == gbs_pkg::ST_PREP)
        begin
            cand_area_reg <= cdx * cdy;
        end
    end

    assign cfg.ready         = 1'b1;
    assign result_out.valid   = out_valid_reg;
    assign result_out.payload = out_data_reg;

    // Kept-box ring: rotate the first count cells so the head walks through
    // every stored box once per scan and returns to its place at the end.
    logic [BOX_W-1:0] cell_box   [MAX_KEPT];
    logic [BOX_W-1:0] cell_shift [MAX_KEPT];
    logic [BOX_W-1:0] cand_box;

    assign cand_box = {cand_x0_reg, cand_y0_reg, cand_x1_reg, cand_y1_reg};

    for (genvar i = 0; i < MAX_KEPT; i++)
    begin : g_ring
        if (i == MAX_KEPT - 1)
        begin : g_tail
            assign cell_shift[i] = cell_box[0];
        end
        else
        begin : g_body
            assign cell_shift[i] = (count_reg == CNT_W'(i + 1)) ? cell_box[0] : cell_box[i + 1];
        end

        gbs_cell #(
            .WIDTH (BOX_W)
        ) u_cell (
            .clk       (clk),
            .shift_en  (issue),
            .shift_in  (cell_shift[i]),
            .load_en   (store_fire && (count_reg == CNT_W'(i))),
            .load_data (cand_box),
            .box       (cell_box[i])
        );
    end

    // Overlap test on the head of the ring
    gbs_iou_pipe #(
        .COORD_BITS (COORD_BITS)
    ) u_iou (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .kx0       ($signed(cell_box[0][4*C-1:3*C])),
        .ky0       ($signed(cell_box[0][3*C-1:2*C])),
        .kx1       ($signed(cell_box[0][2*C-1:C])),
        .ky1       ($signed(cell_box[0][C-1:0])),
        .cx0       (cand_x0_reg),
        .cy0       (cand_y0_reg),
        .cx1       (cand_x1_reg),
        .cy1       (cand_y1_reg),
        .cand_area (cand_area_reg),
        .threshold (thr_reg),
        .status    (iou_status)
    );
endmodule

// ===== hw/rtl/gbs_cell.sv =====
// One storage cell of the kept-box ring: load a new box or take the neighbour's box.
module gbs_cell #(
    parameter int WIDTH = 4 * gbs_pkg::COORD_BITS_DEF
) (
    input  logic             clk,
    input  logic             shift_en,
    input  logic [WIDTH-1:0] shift_in,
    input  logic             load_en,
    input  logic [WIDTH-1:0] load_data,
    output logic [WIDTH-1:0] box
);
    logic [WIDTH-1:0] box_reg;
    logic [WIDTH-1:0] box_next;

    always_comb
    begin
        box_next = box_reg;
        if (load_en)
        begin
            box_next = load_data;
        end
        else if (shift_en)
        begin
            box_next = shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        box_reg <= box_next;
    end

    assign box = box_reg;
endmodule

// ===== hw/rtl/gbs_iou_pipe.sv =====
// Pipelined overlap test of one stored box against the candidate per cycle.
module gbs_iou_pipe #(
    parameter int COORD_BITS = gbs_pkg::COORD_BITS_DEF,
    localparam int D  = COORD_BITS + 1,
    localparam int AW = 2 * D
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          issue,
    input  logic signed [COORD_BITS-1:0]  kx0,
    input  logic signed [COORD_BITS-1:0]  ky0,
    input  logic signed [COORD_BITS-1:0]  kx1,
    input  logic signed [COORD_BITS-1:0]  ky1,
    input  logic signed [COORD_BITS-1:0]  cx0,
    input  logic signed [COORD_BITS-1:0]  cy0,
    input  logic signed [COORD_BITS-1:0]  cx1,
    input  logic signed [COORD_BITS-1:0]  cy1,
    input  logic signed [AW-1:0]          cand_area,
    input  gbs_pkg::thresh_t              threshold,
    output gbs_pkg::iou_status_t          status
);
    localparam int C   = COORD_BITS;
    localparam int IW  = 2 * C;
    localparam int UW  = 2 * C + 3;
    localparam int PW  = UW - 1 + gbs_pkg::THRESH_W;
    localparam int LPAD = PW - IW - gbs_pkg::FRAC_SHIFT;

    // Stage 0: overlap extents and stored box sides
    logic signed [C-1:0] lo_x, hi_x, lo_y, hi_y;
    logic signed [D-1:0] ov_w, ov_h, kdx, kdy;
    logic [C-1:0]        w_next, h_next;

    always_comb
    begin
        lo_x = (kx0 > cx0) ? kx0 : cx0;
        hi_x = (kx1 < cx1) ? kx1 : cx1;
        lo_y = (ky0 > cy0) ? ky0 : cy0;
        hi_y = (ky1 < cy1) ? ky1 : cy1;
        ov_w = $signed({hi_x[C-1], hi_x}) - $signed({lo_x[C-1], lo_x});
        ov_h = $signed({hi_y[C-1], hi_y}) - $signed({lo_y[C-1], lo_y});
        kdx  = $signed({kx1[C-1], kx1}) - $signed({kx0[C-1], kx0});
        kdy  = $signed({ky1[C-1], ky1}) - $signed({ky0[C-1], ky0});
        w_next = ov_w[D-1] ? '0 : ov_w[C-1:0];
        h_next = ov_h[D-1] ? '0 : ov_h[C-1:0];
    end

    logic                v1_reg, v2_reg, v3_reg, v4_reg;
    logic [C-1:0]        w_reg, h_reg;
    logic signed [D-1:0] kdx_reg, kdy_reg;
    logic [IW-1:0]       inter2_reg, inter3_reg, inter4_reg;
    logic signed [AW-1:0] karea_reg;
    logic signed [UW-1:0] uni_reg;
    logic signed [UW-1:0] uni_next;
    logic [PW-1:0]       rhs_reg;
    logic                ok_reg;
    logic                hit;

    always_comb
    begin
        uni_next = $signed({{(UW - AW){karea_reg[AW-1]}}, karea_reg})
                 + $signed({{(UW - AW){cand_area[AW-1]}}, cand_area})
                 - $signed({{(UW - IW){1'b0}}, inter2_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg      <= w_next;
        h_reg      <= h_next;
        kdx_reg    <= kdx;
        kdy_reg    <= kdy;
        inter2_reg <= w_reg * h_reg;
        karea_reg  <= kdx_reg * kdy_reg;
        inter3_reg <= inter2_reg;
        uni_reg    <= uni_next;
        inter4_reg <= inter3_reg;
        ok_reg     <= (inter3_reg != '0) && !uni_reg[UW-1];
        rhs_reg    <= uni_reg[UW-2:0] * threshold;
    end

    assign hit = v4_reg && ok_reg
              && ({{LPAD{1'b0}}, inter4_reg, {gbs_pkg::FRAC_SHIFT{1'b0}}} > rhs_reg);

    assign status.busy = v1_reg | v2_reg | v3_reg | v4_reg;
    assign status.hit  = hit;
endmodule

// ===== hw/rtl/gbs_checker.sv =====
// Port-level checker for the box suppression block, bound to the top level.
module gbs_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic [gbs_pkg::INDEX_W-1:0] in_index,
    input logic                        in_last,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [gbs_pkg::INDEX_W-1:0] out_index,
    input logic                        out_kept,
    input logic                        out_overflow,
    input logic                        out_done
);
    // Track requests in flight: one in the output register, one being judged
    logic [gbs_pkg::INDEX_W:0] q_reg [2];
    logic                      wr_ptr_reg, rd_ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (out_valid && out_ready)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            q_reg[wr_ptr_reg] <= {in_index, in_last};
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({out_index, out_kept, out_overflow, out_done}))
        else $error("result dropped or changed while stalled");

    a_overflow_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_overflow || out_kept))
        else $error("overflow flagged on a suppressed box");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while previous one still being judged");

    a_result_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({out_index, out_done} == q_reg[rd_ptr_reg]))
        else $error("result does not belong to the oldest open request");
endmodule

bind greedy_box_suppression gbs_checker u_gbs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (box_in.valid),
    .in_ready     (box_in.ready),
    .in_index     (box_in.payload.box_index),
    .in_last      (box_in.payload.last_box),
    .out_valid    (result_out.valid),
    .out_ready    (result_out.ready),
    .out_index    (result_out.payload.result_index),
    .out_kept     (result_out.payload.kept),
    .out_overflow (result_out.payload.store_overflow),
    .out_done     (result_out.payload.set_done)
);

// ===== verif/greedy_box_suppression_tb.sv =====
// Self-checking testbench for greedy_box_suppression: box sets, overlap verdicts and store overflow.
`timescale 1ns / 100ps

module greedy_box_suppression_tb;

    localparam int KEPT_DEPTH   = gbs_pkg::MAX_KEPT_DEF;
    localparam int RANDOM_TOTAL = 720;

    // Tracks the boxes kept in the current set and the queue of verdicts still owed
    // by the block. A request is noted when the block accepts it; a verdict is
    // checked when the block hands it over.
    class suppression_scoreboard;
        longint            kept_l [KEPT_DEPTH];
        longint            kept_t [KEPT_DEPTH];
        longint            kept_r [KEPT_DEPTH];
        longint            kept_b [KEPT_DEPTH];
        int                held;
        gbs_pkg::thresh_t  threshold;
        gbs_pkg::box_res_t verdicts_due [$];
        int                mismatches;
        int                accepted;

        function new();
            held       = 0;
            threshold  = gbs_pkg::THRESH_RESET;
            mismatches = 0;
            accepted   = 0;
        endfunction

        // Intersection over union of a stored box and a candidate, against the threshold.
        function bit overlaps_kept(int slot, longint l, longint t, longint r, longint b);
            longint w;
            longint h;
            longint inter;
            longint uni;
            w = ((kept_r[slot] < r) ? kept_r[slot] : r) - ((kept_l[slot] > l) ? kept_l[slot] : l);
            h = ((kept_b[slot] < b) ? kept_b[slot] : b) - ((kept_t[slot] > t) ? kept_t[slot] : t);
            if (w < 0)
                w = 0;
            if (h < 0)
                h = 0;
            inter = w * h;
            uni   = (kept_r[slot] - kept_l[slot]) * (kept_b[slot] - kept_t[slot])
                  + (r - l) * (b - t) - inter;
            if (inter <= 0 || uni < 0)
                return 1'b0;
            return (inter * 64'sd65536) > (longint'(threshold) * uni);
        endfunction

        function string describe(gbs_pkg::box_res_t v);
            return $sformatf("index %0d kept %0b overflow %0b done %0b",
                             v.result_index, v.kept, v.store_overflow, v.set_done);
        endfunction

        function void note_request(gbs_pkg::box_req_t req);
            longint            l;
            longint            t;
            longint            r;
            longint            b;
            bit                keep;
            bit                spill;
            gbs_pkg::box_res_t verdict;
            l     = longint'($signed(req.left_edge));
            t     = longint'($signed(req.top_edge));
            r     = longint'($signed(req.right_edge));
            b     = longint'($signed(req.bottom_edge));
            keep  = 1'b1;
            spill = 1'b0;
            for (int i = 0; i < held; i++)
            begin
                if (overlaps_kept(i, l, t, r, b))
                begin
                    keep = 1'b0;
                    break;
                end
            end
            if (keep)
            begin
                if (held < KEPT_DEPTH)
                begin
                    kept_l[held] = l;
                    kept_t[held] = t;
                    kept_r[held] = r;
                    kept_b[held] = b;
                    held++;
                end
                else
                    spill = 1'b1;
            end
            if (req.last_box)
                held = 0;
            verdict.result_index   = req.box_index;
            verdict.kept           = keep;
            verdict.store_overflow = spill;
            verdict.set_done       = req.last_box;
            verdicts_due.insert(verdicts_due.size(), verdict);
            accepted++;
        endfunction

        function void check_result(gbs_pkg::box_res_t got);
            gbs_pkg::box_res_t want;
            if (verdicts_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %s", describe(got));
                return;
            end
            want = verdicts_due.pop_front();
            if (got.result_index !== want.result_index || got.kept !== want.kept ||
                got.store_overflow !== want.store_overflow || got.set_done !== want.set_done)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %s, got %s", describe(want), describe(got));
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   smooth_run;

    suppression_scoreboard sb = new();

    gbs_stream_if #(.payload_t(gbs_pkg::box_req_t)) box_ch ();
    gbs_stream_if #(.payload_t(gbs_pkg::box_res_t)) result_ch ();
    gbs_stream_if #(.payload_t(gbs_pkg::thresh_t))  cfg_ch ();

    greedy_box_suppression dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .box_in     (box_ch),
        .result_out (result_ch),
        .cfg        (cfg_ch)
    );

    always #2 clk = ~clk;

    // Hard stop in case the block wedges; far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Idle length between requests, or between ready cycles on the result side:
    // mostly none or short, now and then a long one. Smooth stretches never idle.
    function automatic int pick_gap();
        int roll;
        if (smooth_run)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Clamp an edge into the signed 16-bit coordinate range.
    function automatic logic signed [gbs_pkg::EDGE_W-1:0] coord_of(int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[gbs_pkg::EDGE_W-1:0];
    endfunction

    // Offer one box request after a random gap; return at the edge that takes it.
    // Valid stays high afterwards: the next call either replaces the payload or drops it.
    task automatic send_box(input int idx, input int l, input int t, input int r, input int b,
                            input bit last);
        gbs_pkg::box_req_t req;
        int                gap;
        req.box_index   = idx[gbs_pkg::INDEX_W-1:0];
        req.left_edge   = coord_of(l);
        req.top_edge    = coord_of(t);
        req.right_edge  = coord_of(r);
        req.bottom_edge = coord_of(b);
        req.last_box    = last;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            box_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        box_ch.valid   <= 1'b1;
        box_ch.payload <= req;
        do
            @(posedge clk);
        while (!box_ch.ready);
        sb.note_request(req);
    endtask

    // Drop the box channel, wait for every owed verdict, then let the pipeline drain.
    task automatic settle();
        int guard;
        guard = 0;
        @(negedge clk);
        box_ch.valid <= 1'b0;
        while (sb.verdicts_due.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (80) @(posedge clk);
    endtask

    // Write the overlap threshold; only called with the block idle.
    task automatic write_threshold(input gbs_pkg::thresh_t value);
        @(negedge clk);
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sb.threshold = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // One set of boxes scattered around a common centre, so that overlaps are frequent.
    // A few boxes are pure noise, near repeats of the previous one, or turned inside out.
    task automatic send_cluster_set(input int count);
        int cx;
        int cy;
        int spread;
        int roll;
        int x;
        int y;
        int w;
        int h;
        int l;
        int t;
        int r;
        int b;
        int swap;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            spread = $urandom_range(4, 64);
        else if (roll < 90)
            spread = $urandom_range(65, 2000);
        else
            spread = $urandom_range(2001, 20000);
        cx = int'($urandom_range(0, 65535)) - 32768;
        cy = int'($urandom_range(0, 65535)) - 32768;
        l = 0;
        t = 0;
        r = 0;
        b = 0;
        for (int k = 0; k < count; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
            begin
                l = int'($urandom_range(0, 65535)) - 32768;
                t = int'($urandom_range(0, 65535)) - 32768;
                r = int'($urandom_range(0, 65535)) - 32768;
                b = int'($urandom_range(0, 65535)) - 32768;
            end
            else if (roll < 18 && k > 0)
            begin
                // repeat the previous box, nudged by at most one step
                l = l + int'($urandom_range(0, 2)) - 1;
                r = r + int'($urandom_range(0, 2)) - 1;
            end
            else
            begin
                x = cx + int'($urandom_range(0, 4 * spread)) - 2 * spread;
                y = cy + int'($urandom_range(0, 4 * spread)) - 2 * spread;
                w = $urandom_range(1, 2 * spread);
                h = $urandom_range(1, 2 * spread);
                l = x - w / 2;
                t = y - h / 2;
                r = l + w;
                b = t + h;
                if ($urandom_range(0, 19) == 0)
                begin
                    swap = l;
                    l    = r;
                    r    = swap;
                end
            end
            send_box($urandom_range(0, 65535), l, t, r, b, k == count - 1);
        end
    endtask

    // A set that fills the store: the first 64 tiles are disjoint and all kept.
    // Beyond that, repeats of stored tiles are suppressed and fresh tiles overflow.
    task automatic send_full_store_set();
        int count;
        int size;
        int pitch;
        int ox;
        int oy;
        int tile;
        count = $urandom_range(66, 72);
        size  = $urandom_range(2, 60);
        pitch = size + int'($urandom_range(0, 4));
        ox    = int'($urandom_range(0, 60000)) - 32768;
        oy    = int'($urandom_range(0, 60000)) - 32768;
        for (int k = 0; k < count; k++)
        begin
            tile = (k < KEPT_DEPTH) ? k : int'($urandom_range(0, 71));
            send_box($urandom_range(0, 65535),
                     ox + (tile % 9) * pitch, oy + (tile / 9) * pitch,
                     ox + (tile % 9) * pitch + size, oy + (tile / 9) * pitch + size,
                     k == count - 1);
        end
    endtask

    // Check every verdict the block hands over, sampled at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_result(result_ch.payload);
    end

    // Result side: random stalls, plus one long hold-off once enough requests have
    // gone in, so that the output register and the candidate stage back up and the
    // block stops taking requests.
    initial
    begin : result_drain
        int  stall;
        int  hold;
        bit  pressure_done;
        stall         = 0;
        hold          = 0;
        pressure_done = 1'b0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!pressure_done && sb.accepted >= 200)
            begin
                hold          = 400;
                pressure_done = 1'b1;
            end
            if (hold > 0)
            begin
                hold--;
                result_ch.ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                stall = pick_gap();
                if (stall > 0)
                begin
                    stall--;
                    result_ch.ready <= 1'b0;
                end
                else
                    result_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        int               phase;
        int               phase_end;
        int               roll;
        gbs_pkg::thresh_t level;
        clk            = 1'b0;
        rst_n          = 1'b0;
        smooth_run     = 1'b0;
        box_ch.valid   = 1'b0;
        box_ch.payload = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.payload = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset threshold (one half). Identical boxes, partial overlap below half,
        // the whole coordinate plane, inside-out boxes and touching edges.
        send_box(0,          0,      0,     80,     80, 1'b0);
        send_box(65535,      0,      0,     80,     80, 1'b0);
        send_box(1,         40,      0,    120,     80, 1'b0);
        send_box(2,     -32768, -32768,  32767,  32767, 1'b0);
        send_box(3,        100,    100,     20,     20, 1'b0);
        send_box(4,      32767,  32767, -32768, -32768, 1'b0);
        send_box(5,         80,      0,    160,     80, 1'b0);
        send_box(6,          0,      0,     80,     80, 1'b1);
        // A single-box set of zero area closes at once.
        send_box(7,      32767,  32767,  32767,  32767, 1'b1);
        settle();

        // Threshold zero: any shared area at all suppresses; touching does not.
        write_threshold('0);
        send_box(8,          0,      0,     80,     80, 1'b0);
        send_box(9,         79,     79,    200,    200, 1'b0);
        send_box(10,      -100,   -100,    -20,    -20, 1'b0);
        send_box(11,        80,     80,     90,     90, 1'b1);
        settle();

        // Threshold at its top: an exact match suppresses, a box one row short of it does not.
        write_threshold(16'hFFFF);
        send_box(12,         0,      0,    100,    100, 1'b0);
        send_box(13,         0,      0,    100,    100, 1'b0);
        send_box(14,         0,      0,    100,     99, 1'b0);
        send_box(15,    -32768, -32768, -32767, -32767, 1'b1);
        settle();

        // Random phases, each under its own threshold; the third runs without idling.
        phase = 0;
        while (sb.accepted < RANDOM_TOTAL)
        begin
            roll = $urandom_range(0, 7);
            case (roll)
                0:       level = '0;
                1:       level = 16'hFFFF;
                2:       level = 16'd1;
                3:       level = gbs_pkg::THRESH_RESET;
                4:       level = gbs_pkg::thresh_t'($urandom_range(0, 65535));
                default: level = gbs_pkg::thresh_t'($urandom_range(16384, 52000));
            endcase
            write_threshold(level);
            smooth_run = (phase == 2);
            phase_end  = (sb.accepted + 130 < RANDOM_TOTAL) ? sb.accepted + 130 : RANDOM_TOTAL;
            if (phase == 1)
                send_full_store_set();
            while (sb.accepted < phase_end)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    send_full_store_set();
                else if (roll < 88)
                    send_cluster_set($urandom_range(1, 10));
                else
                    send_cluster_set($urandom_range(11, 40));
            end
            settle();
            smooth_run = 1'b0;
            phase++;
        end

        if (sb.mismatches == 0 && sb.verdicts_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
